// ===== src/mmrs_pkg.sv =====
`default_nettype none

package mmrs_pkg;

  localparam int DEF_INNER_DIM  = 16;
  localparam int DEF_OUT_COLS   = 16;
  localparam int DEF_ELEM_WIDTH = 32;

  // fixed field widths of the stream payload
  localparam int IDX_W       = 6;
  localparam int VAL_W       = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam int Q_DEPTH = 2;

  localparam logic KIND_B = 1'b0;
  localparam logic KIND_A = 1'b1;

  typedef struct packed {
    logic is_a;
    logic first;
    logic emit;
  } op_ctrl_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

`default_nettype wire

// ===== src/mmrs_front.sv =====
`default_nettype none

module mmrs_front #(
  parameter int INNER_DIM  = 16,
  parameter int OUT_COLS   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int BA_W       = 8
) (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [mmrs_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                           in_tuser,
  input  wire logic                           q_ready,
  output logic                                q_push,
  output mmrs_pkg::op_ctrl_t                  q_ctrl,
  output logic [mmrs_pkg::IDX_W-1:0]          q_row,
  output logic [BA_W-1:0]                     q_addr,
  output logic [ELEM_WIDTH-1:0]               q_value
);
  import mmrs_pkg::*;

  localparam int IW1     = IDX_W + 1;
  localparam int AW_FULL = 2 * IDX_W + 1;
  localparam logic [IW1-1:0] K_LIM = IW1'(INNER_DIM);
  localparam logic [IW1-1:0] N_LIM = IW1'(OUT_COLS);

  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] val_s;
  logic                    b_ok;
  logic                    a_ok;
  logic                    class_ok;
  logic [AW_FULL-1:0]      b_addr_full;
  logic [AW_FULL-1:0]      a_base_full;

  assign row   = in_tdata[IDX_W-1:0];
  assign col   = in_tdata[2*IDX_W-1:IDX_W];
  assign val_s = signed'(in_tdata[2*IDX_W+VAL_W-1:2*IDX_W]);

  assign b_ok = ({1'b0, row} < K_LIM) && ({1'b0, col} < N_LIM);
  assign a_ok = ({1'b0, col} < K_LIM);

  // row-major placement of B, and the first entry of B row k for an A element
  assign b_addr_full = AW_FULL'(row) * AW_FULL'(OUT_COLS) + AW_FULL'(col);
  assign a_base_full = AW_FULL'(col) * AW_FULL'(OUT_COLS);

  always_comb begin
    q_ctrl.is_a  = (in_tuser == KIND_A);
    q_ctrl.first = (col == '0);
    q_ctrl.emit  = ({1'b0, col} == K_LIM - IW1'(1));
    class_ok     = q_ctrl.is_a ? a_ok : b_ok;
    q_addr       = q_ctrl.is_a ? a_base_full[BA_W-1:0] : b_addr_full[BA_W-1:0];
  end

  // out-of-range requests are taken and dropped here
  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready && class_ok;
  assign q_row     = row;
  assign q_value   = ELEM_WIDTH'(val_s);

endmodule

`default_nettype wire

// ===== src/mmrs_queue.sv =====
`default_nettype none

module mmrs_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output logic               pop_valid
);
  import mmrs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/mmrs_back.sv =====
`default_nettype none

module mmrs_back #(
  parameter int INNER_DIM  = 16,
  parameter int OUT_COLS   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int BA_W       = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_valid,
  output logic                                 q_pop,
  input  wire mmrs_pkg::op_ctrl_t              q_ctrl,
  input  wire logic [mmrs_pkg::IDX_W-1:0]      q_row,
  input  wire logic [BA_W-1:0]                 q_addr,
  input  wire logic [ELEM_WIDTH-1:0]           q_value,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [mmrs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast
);
  import mmrs_pkg::*;

  localparam int W     = ELEM_WIDTH;
  localparam int JW    = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
  localparam int PAD_W = OUT_TDATA_W - VAL_W - 2 * IDX_W;
  localparam logic [JW-1:0] J_LAST = JW'(OUT_COLS - 1);

  back_state_t      state_r, state_nxt;
  logic [JW-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0] cur_row_r;
  logic             cur_first_r;
  logic             cur_emit_r;
  logic [BA_W-1:0]  base_r;
  logic [W-1:0]     a_r;

  logic             adv;
  logic             pipe_empty;
  logic             issue;
  logic             load_item;
  logic             b_wr;
  logic [BA_W-1:0]  rd_addr;

  logic [W-1:0]     b_mem   [INNER_DIM*OUT_COLS];
  logic [W-1:0]     acc_mem [OUT_COLS];
  logic [W-1:0]     b_rd_r;
  logic [W-1:0]     acc_rd_r;

  logic             v1_r, v2_r, v3_r;
  logic [JW-1:0]    j1_r, j2_r, j3_r;
  logic [W-1:0]     acc2_r, acc3_r;
  logic [W-1:0]     prod_full;
  logic [W-1:0]     prod_r;
  logic [W-1:0]     sum;
  logic             acc_we;
  logic             out_load;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_val_r;
  logic [IDX_W-1:0] out_row_r;
  logic [IDX_W-1:0] out_col_r;
  logic             out_last_r;

  // whole back pipeline holds while a result waits in the output register
  assign adv        = !out_valid_r || out_tready;
  assign pipe_empty = !(v1_r || v2_r || v3_r);
  assign rd_addr    = base_r + BA_W'(j_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && pipe_empty && q_ctrl.is_a) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv && (j_r == J_LAST)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    unique case (state_r)
      BK_IDLE: q_pop = q_valid && pipe_empty;
      BK_RUN:  issue = adv;
      default: begin
        q_pop = 1'b0;
        issue = 1'b0;
      end
    endcase
    b_wr      = q_pop && !q_ctrl.is_a;
    load_item = q_pop && q_ctrl.is_a;
  end

  always_comb begin
    j_nxt = j_r;
    if (load_item) begin
      j_nxt = '0;
    end else if (issue) begin
      j_nxt = j_r + JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      j_r     <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      if (adv) begin
        v1_r <= issue;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      cur_row_r   <= q_row;
      cur_first_r <= q_ctrl.first;
      cur_emit_r  <= q_ctrl.emit;
      base_r      <= q_addr;
      a_r         <= q_value;
    end
  end

  always_ff @(posedge clk) begin
    if (b_wr) begin
      b_mem[q_addr] <= q_value;
    end
    if (adv) begin
      b_rd_r <= b_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[j3_r] <= sum;
    end
    if (adv) begin
      acc_rd_r <= acc_mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j1_r   <= j_r;
      j2_r   <= j1_r;
      j3_r   <= j2_r;
      acc2_r <= acc_rd_r;
      acc3_r <= acc2_r;
      prod_r <= prod_full;
    end
  end

  // low ELEM_WIDTH bits of the product, split into 32-bit halves when wide
  if (W <= 32) begin : g_mul_narrow
    logic [W-1:0] pp_r;
    always_ff @(posedge clk) begin
      if (adv) begin
        pp_r <= a_r * b_rd_r;
      end
    end
    assign prod_full = pp_r;
  end else begin : g_mul_wide
    localparam int HW = W - 32;
    logic [63:0]   ll_r;
    logic [HW-1:0] lh_r;
    logic [HW-1:0] hl_r;
    always_ff @(posedge clk) begin
      if (adv) begin
        ll_r <= 64'(a_r[31:0]) * 64'(b_rd_r[31:0]);
        lh_r <= a_r[HW-1:0] * b_rd_r[W-1:32];
        hl_r <= a_r[W-1:32] * b_rd_r[HW-1:0];
      end
    end
    assign prod_full = ll_r[W-1:0] + {HW'(lh_r + hl_r), 32'b0};
  end

  assign sum      = cur_first_r ? prod_r : acc3_r + prod_r;
  assign acc_we   = v3_r && adv;
  assign out_load = acc_we && cur_emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_val_r  <= VAL_W'(signed'(sum));
      out_row_r  <= cur_row_r;
      out_col_r  <= IDX_W'(j3_r);
      out_last_r <= (j3_r == J_LAST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_col_r, out_row_r, out_val_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== src/matrix_multiply_row_stream.sv =====
// B element: taken into the queue, then written to the B store when the back end pops it.
// A element: leaves the queue, then visits all OUT_COLS columns through the one shared
// multiply-accumulate, one column a cycle while the output is not stalled, then the
// v1, v2 and v3 stages drain; the next queue entry is popped only once they are empty.
// On the last inner index the C row leaves one column a cycle while out_tready is high;
// output stalls hold the whole back pipeline.
// Synchronous active-low reset clears control only; B store and accumulators undefined.
`default_nettype none

module matrix_multiply_row_stream #(
  parameter int INNER_DIM  = mmrs_pkg::DEF_INNER_DIM,
  parameter int OUT_COLS   = mmrs_pkg::DEF_OUT_COLS,
  parameter int ELEM_WIDTH = mmrs_pkg::DEF_ELEM_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mmrs_pkg::IN_TDATA_W-1:0]  in_tdata,  // row_index, col_index, value
  input  wire logic                             in_tuser,  // kind
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [mmrs_pkg::OUT_TDATA_W-1:0]      out_tdata, // product_value, out_row, out_col
  output logic                                  out_tlast
);
  import mmrs_pkg::*;

  localparam int BA_W = (INNER_DIM * OUT_COLS > 1) ? $clog2(INNER_DIM * OUT_COLS) : 1;
  localparam int QW   = $bits(op_ctrl_t) + IDX_W + BA_W + ELEM_WIDTH;

  logic                  q_ready;
  logic                  f_push;
  op_ctrl_t              f_ctrl;
  logic [IDX_W-1:0]      f_row;
  logic [BA_W-1:0]       f_addr;
  logic [ELEM_WIDTH-1:0] f_value;

  logic [QW-1:0]         q_in;
  logic [QW-1:0]         q_out;
  logic                  q_valid;
  logic                  q_pop;
  op_ctrl_t              b_ctrl;
  logic [IDX_W-1:0]      b_row;
  logic [BA_W-1:0]       b_addr;
  logic [ELEM_WIDTH-1:0] b_value;

  mmrs_front #(
    .INNER_DIM  (INNER_DIM),
    .OUT_COLS   (OUT_COLS),
    .ELEM_WIDTH (ELEM_WIDTH),
    .BA_W       (BA_W)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .q_push    (f_push),
    .q_ctrl    (f_ctrl),
    .q_row     (f_row),
    .q_addr    (f_addr),
    .q_value   (f_value)
  );

  assign q_in = {f_ctrl, f_row, f_addr, f_value};

  mmrs_queue #(
    .DW    (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_data   (q_out),
    .pop_valid  (q_valid)
  );

  assign {b_ctrl, b_row, b_addr, b_value} = q_out;

  mmrs_back #(
    .INNER_DIM  (INNER_DIM),
    .OUT_COLS   (OUT_COLS),
    .ELEM_WIDTH (ELEM_WIDTH),
    .BA_W       (BA_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_ctrl     (b_ctrl),
    .q_row      (b_row),
    .q_addr     (b_addr),
    .q_value    (b_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mmrs_pkg::*;

  localparam int INNER_DIM = DEF_INNER_DIM;
  localparam int OUT_COLS  = DEF_OUT_COLS;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } c_elem_t;

  // running model of B, the row accumulators and the C elements still owed
  class gemm_row_checker;
    logic [VAL_W-1:0] b_mat [INNER_DIM][OUT_COLS];
    logic [VAL_W-1:0] acc [OUT_COLS];
    c_elem_t expected_c [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(logic kind, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                               logic [VAL_W-1:0] val);
      logic [VAL_W-1:0] prod;
      c_elem_t e;
      if (kind == KIND_B) begin
        if (row < INNER_DIM && col < OUT_COLS) b_mat[row][col] = val;
      end else if (col < INNER_DIM) begin
        for (int j = 0; j < OUT_COLS; j++) begin
          prod = val * b_mat[col][j];
          acc[j] = (col == 0) ? prod : acc[j] + prod;
        end
        if (col == INNER_DIM - 1) begin
          for (int j = 0; j < OUT_COLS; j++) begin
            e.value = acc[j];
            e.row   = row;
            e.col   = j[IDX_W-1:0];
            e.last  = (j == OUT_COLS - 1);
            expected_c.push_back(e);
          end
        end
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      c_elem_t e;
      if (expected_c.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h last %b",
                 $time, tdata, tlast);
        errors++;
        return;
      end
      e = expected_c.pop_front();
      if (tdata[31:0] !== e.value) begin
        $display("%0t: product_value mismatch, expected %h actual %h",
                 $time, e.value, tdata[31:0]);
        errors++;
      end
      if (tdata[37:32] !== e.row) begin
        $display("%0t: out_row mismatch, expected %0d actual %0d", $time, e.row, tdata[37:32]);
        errors++;
      end
      if (tdata[43:38] !== e.col) begin
        $display("%0t: out_col mismatch, expected %0d actual %0d", $time, e.col, tdata[43:38]);
        errors++;
      end
      if (tlast !== e.last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, e.last, tlast);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;  // row_index, col_index, value
  logic                   in_tuser = KIND_B;  // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // product_value, out_row, out_col
  logic                   out_tlast;

  gemm_row_checker c_check = new();

  // stimulus-side view of which B entries hold data and whether a row was started
  bit b_written [INNER_DIM][OUT_COLS];
  bit acc_started = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int results_seen = 0;
  int counted_reqs = 0;

  matrix_multiply_row_stream i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      c_check.check_result(out_tdata, out_tlast);
      results_seen++;
    end
  end

  function automatic logic [VAL_W-1:0] rand_elem();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      4: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit row_full(int k);
    for (int j = 0; j < OUT_COLS; j++) if (!b_written[k][j]) return 1'b0;
    return 1'b1;
  endfunction

  // called at a clock edge, returns at the edge where the request was taken
  task automatic send_req(logic kind, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                          logic [VAL_W-1:0] val);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, val, col, row};
    do @(posedge clk); while (!in_tready);
    c_check.note_request(kind, row, col, val);
    if (kind == KIND_B) begin
      if (row < INNER_DIM && col < OUT_COLS) begin
        b_written[row][col] = 1'b1;
        counted_reqs++;
      end
    end else if (col < INNER_DIM) begin
      if (col == 0) acc_started = 1'b1;
      counted_reqs++;
    end
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
  endtask

  task automatic load_b_row(int k);
    for (int j = 0; j < OUT_COLS; j++)
      send_req(KIND_B, k[IDX_W-1:0], j[IDX_W-1:0], rand_elem());
  endtask

  // one C row: start, accumulate over a random subset of loaded rows, finish
  task automatic send_a_row();
    logic [IDX_W-1:0] i;
    i = IDX_W'($urandom_range(0, 63));
    send_req(KIND_A, i, '0, rand_elem());
    for (int k = 1; k < INNER_DIM - 1; k++)
      if (row_full(k) && $urandom_range(0, 1)) send_req(KIND_A, i, k[IDX_W-1:0], rand_elem());
    send_req(KIND_A, i, IDX_W'(INNER_DIM - 1), rand_elem());
  endtask

  task automatic wait_drained();
    while (c_check.expected_c.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int k;
    bit paused;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rows 0 and the last one are needed before any row can be emitted
    send_req(KIND_B, 6'd0, 6'd0, 32'h8000_0000);
    send_req(KIND_B, 6'd0, 6'd1, 32'h7fff_ffff);
    send_req(KIND_B, 6'd0, 6'd2, 32'h0000_0000);
    send_req(KIND_B, 6'd0, 6'd3, 32'h0000_0001);
    send_req(KIND_B, 6'd0, 6'd4, 32'hffff_ffff);
    for (int j = 5; j < OUT_COLS; j++) send_req(KIND_B, 6'd0, j[IDX_W-1:0], $urandom);
    load_b_row(INNER_DIM - 1);

    // out-of-range B stores are dropped
    send_req(KIND_B, IDX_W'(INNER_DIM), 6'd0, 32'hdead_beef);
    send_req(KIND_B, 6'd0, IDX_W'(OUT_COLS), 32'hdead_beef);
    send_req(KIND_B, 6'd63, 6'd63, 32'hffff_ffff);
    send_req(KIND_A, 6'd5, 6'd0, 32'h8000_0000);
    // out-of-range inner index is dropped
    send_req(KIND_A, 6'd5, IDX_W'(INNER_DIM), 32'h1234_5678);
    send_req(KIND_A, 6'd63, 6'd63, 32'hffff_ffff);
    // finish on a row other than the one started
    send_req(KIND_A, 6'd63, IDX_W'(INNER_DIM - 1), 32'h7fff_ffff);
    send_req(KIND_A, 6'd42, 6'd0, 32'hffff_ffff);
    send_req(KIND_A, 6'd0, IDX_W'(INNER_DIM - 1), 32'h0000_0001);
    // finish twice more with no fresh start, accumulating onto the old sums
    send_req(KIND_A, 6'd21, IDX_W'(INNER_DIM - 1), 32'h0000_0000);
    send_req(KIND_A, 6'd63, IDX_W'(INNER_DIM - 1), 32'h8000_0000);

    counted_reqs = 0;
    while (counted_reqs < 330) begin
      pick = $urandom_range(0, 99);
      if (!paused && counted_reqs >= 150) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        wait_drained();
      end
      if (pick < 50) begin
        send_a_row();
      end else if (pick < 62) begin
        load_b_row($urandom_range(1, INNER_DIM - 2));
      end else if (pick < 78) begin
        send_req(KIND_B, IDX_W'($urandom_range(0, INNER_DIM - 1)),
                 IDX_W'($urandom_range(0, OUT_COLS - 1)), rand_elem());
      end else if (pick < 88) begin
        // stray step into the running accumulators
        k = $urandom_range(0, INNER_DIM - 1);
        if (row_full(k) && acc_started)
          send_req(KIND_A, IDX_W'($urandom_range(0, 63)), k[IDX_W-1:0], rand_elem());
      end else if (pick < 94) begin
        if ($urandom_range(0, 1))
          send_req(KIND_B, IDX_W'($urandom_range(INNER_DIM, 63)),
                   IDX_W'($urandom_range(0, 63)), $urandom);
        else
          send_req(KIND_B, IDX_W'($urandom_range(0, 63)),
                   IDX_W'($urandom_range(OUT_COLS, 63)), $urandom);
      end else begin
        send_req(KIND_A, IDX_W'($urandom_range(0, 63)),
                 IDX_W'($urandom_range(INNER_DIM, 63)), $urandom);
      end
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);
    if (c_check.errors == 0 && c_check.expected_c.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 13);
      // one long hold-off so the block backs up into its input
      if (!held && results_seen >= 100) begin
        held  = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
    end
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
